/* hdl/simplex_vertex_rank_centroid_assert.svh */
// Assertion macros shared by the simplex vertex rank and centroid block.
`ifndef SIMPLEX_VERTEX_RANK_CENTROID_ASSERT_SVH
`define SIMPLEX_VERTEX_RANK_CENTROID_ASSERT_SVH

// Same-cycle implication, sampled on clk and disabled while rst_n is low.
`define SVRC_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk and disabled while rst_n is low.
`define SVRC_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hdl/svrc_pkg.sv */
// Package with field widths, codes and defaults of the simplex vertex block.
package svrc_pkg;

    localparam int DEF_MAX_DIMS     = 8;
    localparam int DEF_MAX_VERTICES = 9;

    localparam int FUNC_W  = 3;
    localparam int VTX_W   = 4;
    localparam int DIM_W   = 3;
    localparam int DATA_W  = 32;
    localparam int KIND_W  = 2;
    localparam int CFG_W   = 4;
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;

    localparam logic [FUNC_W-1:0] FUNC_WR_COORD = 3'd0;
    localparam logic [FUNC_W-1:0] FUNC_WR_COST  = 3'd1;
    localparam logic [FUNC_W-1:0] FUNC_RANK     = 3'd2;
    localparam logic [FUNC_W-1:0] FUNC_CENTROID = 3'd3;
    localparam logic [FUNC_W-1:0] FUNC_ANSWER   = 3'd4;

    localparam logic [KIND_W-1:0] KIND_RANK     = 2'd0;
    localparam logic [KIND_W-1:0] KIND_CENTROID = 2'd1;
    localparam logic [KIND_W-1:0] KIND_BEST     = 2'd2;

    localparam logic REG_DIMENSIONS   = 1'b0;
    localparam logic REG_VERTEX_COUNT = 1'b1;

    localparam logic [CFG_W-1:0] DIMENSIONS_RST   = 4'd2;
    localparam logic [CFG_W-1:0] VERTEX_COUNT_RST = 4'd3;

    localparam logic signed [DATA_W-1:0] Q_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [DATA_W-1:0] Q_MIN = 32'sh8000_0000;

endpackage

/* hdl/svrc_cmd_if.sv */
// Request channel of the simplex vertex block: valid, ready and one request.
interface svrc_cmd_if;
    logic                                      valid;
    logic                                      ready;
    logic        [svrc_pkg::FUNC_W-1:0]        func;
    logic        [svrc_pkg::VTX_W-1:0]         vertex;
    logic        [svrc_pkg::DIM_W-1:0]         dim_index;
    logic signed [svrc_pkg::DATA_W-1:0]        value;

    modport source (output valid, func, vertex, dim_index, value, input ready);
    modport sink   (input valid, func, vertex, dim_index, value, output ready);
endinterface

/* hdl/svrc_res_if.sv */
// Result channel of the simplex vertex block: valid, ready and one result.
interface svrc_res_if;
    logic                                      valid;
    logic                                      ready;
    logic        [svrc_pkg::KIND_W-1:0]        kind;
    logic        [svrc_pkg::VTX_W-1:0]         worst_index;
    logic        [svrc_pkg::VTX_W-1:0]         second_worst_index;
    logic        [svrc_pkg::VTX_W-1:0]         best_index;
    logic        [svrc_pkg::DIM_W-1:0]         out_dim;
    logic signed [svrc_pkg::DATA_W-1:0]        coord_value;
    logic signed [svrc_pkg::DATA_W-1:0]        best_cost;
    logic                                      last;

    modport source (output valid, kind, worst_index, second_worst_index, best_index,
                    out_dim, coord_value, best_cost, last, input ready);
    modport sink   (input valid, kind, worst_index, second_worst_index, best_index,
                    out_dim, coord_value, best_cost, last, output ready);
endinterface

/* hdl/simplex_vertex_rank_centroid.sv */
// Nelder-Mead vertex store with sequenced ranking, centroid and answer readout.
// Rank reads the N costs in use, one cost read a cycle, in a worst/best pass and a
// second-worst pass. Centroid divides each coordinate sum, worst left out, by N-1 in
// S = 32+clog2(MAX_VERTICES) divider steps. Answer ranks, then gives the best vertex's
// D coordinates. Results wait in one output register; a request is taken only in idle.
// rst_n clears the sequencer and rank registers and restores the configuration defaults.
`include "simplex_vertex_rank_centroid_assert.svh"

module simplex_vertex_rank_centroid #(
    parameter int MAX_DIMS     = svrc_pkg::DEF_MAX_DIMS,
    parameter int MAX_VERTICES = svrc_pkg::DEF_MAX_VERTICES
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [svrc_pkg::PADDR_W-1:0]   paddr,
    input  logic [svrc_pkg::PDATA_W-1:0]   pwdata,
    output logic [svrc_pkg::PDATA_W-1:0]   prdata,
    output logic                           pready,
    svrc_cmd_if.sink                       cmd,
    svrc_res_if.source                     result
);

    localparam int VI_W  = $clog2(MAX_VERTICES);
    localparam int DI_W  = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
    localparam int VC_W  = $clog2(MAX_VERTICES + 1);
    localparam int DC_W  = $clog2(MAX_DIMS + 1);
    localparam int SUM_W = svrc_pkg::DATA_W + $clog2(MAX_VERTICES);
    localparam int DS_W  = $clog2(SUM_W + 1);
    localparam int DW    = svrc_pkg::DATA_W;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_RANK_A,
        ST_RANK_B,
        ST_RANK_DONE,
        ST_RANK_PUT,
        ST_CEN_SUM,
        ST_DIV_LOAD,
        ST_DIV_RUN,
        ST_CEN_PUT,
        ST_ANS_COST,
        ST_ANS_RD,
        ST_ANS_PUT
    } state_t;

    state_t st_reg, st_next;

    logic [VC_W-1:0]                  cnt_reg, cnt_next;
    logic [DC_W-1:0]                  dcnt_reg, dcnt_next;
    logic                             rd_vld_reg, rd_vld_next;
    logic [VI_W-1:0]                  rd_idx_reg, rd_idx_next;
    logic                             ans_reg, ans_next;

    logic [VI_W-1:0]                  w_reg, w_next;
    logic [VI_W-1:0]                  w2_reg, w2_next;
    logic [VI_W-1:0]                  b_reg, b_next;
    logic signed [DW-1:0]             wc_reg, wc_next;
    logic signed [DW-1:0]             w2c_reg, w2c_next;
    logic signed [DW-1:0]             bc_reg, bc_next;
    logic                             have2_reg, have2_next;

    logic [VI_W-1:0]                  worst_reg, worst_next;
    logic [VI_W-1:0]                  second_worst_reg, second_worst_next;
    logic [VI_W-1:0]                  best_reg, best_next;

    logic signed [SUM_W-1:0]          sum_reg, sum_next;
    logic                             neg_reg, neg_next;
    logic [SUM_W-1:0]                 quo_reg, quo_next;
    logic [VC_W-1:0]                  rem_reg, rem_next;
    logic [DS_W-1:0]                  dstep_reg, dstep_next;
    logic signed [DW-1:0]             best_cost_reg, best_cost_next;

    logic [svrc_pkg::CFG_W-1:0]       dims_reg, dims_next;
    logic [svrc_pkg::CFG_W-1:0]       vcnt_reg, vcnt_next;

    logic                             out_valid_reg, out_valid_next;
    logic [svrc_pkg::KIND_W-1:0]      out_kind_reg, out_kind_next;
    logic [VI_W-1:0]                  out_worst_reg, out_worst_next;
    logic [VI_W-1:0]                  out_second_reg, out_second_next;
    logic [VI_W-1:0]                  out_best_reg, out_best_next;
    logic [svrc_pkg::DIM_W-1:0]       out_dim_reg, out_dim_next;
    logic signed [DW-1:0]             out_coord_reg, out_coord_next;
    logic signed [DW-1:0]             out_cost_reg, out_cost_next;
    logic                             out_last_reg, out_last_next;

    logic signed [DW-1:0]             cost_mem [MAX_VERTICES];
    logic signed [DW-1:0]             coord_mem [MAX_VERTICES][MAX_DIMS];
    logic signed [DW-1:0]             cost_rd_reg;
    logic signed [DW-1:0]             coord_rd_reg;

    logic [VI_W-1:0]                  rd_v;
    logic [DI_W-1:0]                  rd_d;
    logic [DC_W-1:0]                  nd_use;
    logic [VC_W-1:0]                  nv_use;
    logic [VC_W-1:0]                  dvsr;
    logic [VC_W:0]                    rem_sh;
    logic                             q_bit;
    logic                             q_hi;
    logic signed [DW-1:0]             mean;
    logic                             cmd_acc;
    logic                             wr_cost;
    logic                             wr_coord;
    logic                             cfg_wr;
    logic                             cfg_idx;
    logic                             out_free;
    logic                             dim_last;

    // Register values outside the legal range are clamped when used.
    always_comb
    begin
        if (dims_reg == '0)
            nd_use = DC_W'(1);
        else if (32'(dims_reg) > MAX_DIMS)
            nd_use = DC_W'(MAX_DIMS);
        else
            nd_use = DC_W'(dims_reg);

        if (32'(vcnt_reg) < 2)
            nv_use = VC_W'(2);
        else if (32'(vcnt_reg) > MAX_VERTICES)
            nv_use = VC_W'(MAX_VERTICES);
        else
            nv_use = VC_W'(vcnt_reg);
    end

    assign dvsr     = nv_use - VC_W'(1);
    assign cmd_acc  = cmd.valid && (st_reg == ST_IDLE);
    assign cmd.ready = (st_reg == ST_IDLE);
    assign wr_cost  = cmd_acc && (cmd.func == svrc_pkg::FUNC_WR_COST)
                      && (32'(cmd.vertex) < MAX_VERTICES);
    assign wr_coord = cmd_acc && (cmd.func == svrc_pkg::FUNC_WR_COORD)
                      && (32'(cmd.vertex) < MAX_VERTICES)
                      && (32'(cmd.dim_index) < MAX_DIMS);

    assign cfg_wr  = psel && penable && pwrite && pready;
    assign cfg_idx = paddr[2];
    assign pready  = 1'b1;

    always_comb
    begin
        case (cfg_idx)
            svrc_pkg::REG_DIMENSIONS:   prdata = svrc_pkg::PDATA_W'(dims_reg);
            svrc_pkg::REG_VERTEX_COUNT: prdata = svrc_pkg::PDATA_W'(vcnt_reg);
            default:                    prdata = '0;
        endcase
    end

    // One read address per cycle for each store; the read data is registered for the next cycle.
    always_comb
    begin
        rd_v = '0;
        rd_d = DI_W'(dcnt_reg);
        case (st_reg)
            ST_RANK_A, ST_RANK_B, ST_CEN_SUM:
            begin
                if (cnt_reg < nv_use)
                    rd_v = VI_W'(cnt_reg);
            end
            ST_ANS_COST, ST_ANS_RD, ST_ANS_PUT:
            begin
                rd_v = best_reg;
            end
            default:
            begin
                rd_v = '0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (wr_cost)
            cost_mem[VI_W'(cmd.vertex)] <= cmd.value;
        if (wr_coord)
            coord_mem[VI_W'(cmd.vertex)][DI_W'(cmd.dim_index)] <= cmd.value;
        cost_rd_reg  <= cost_mem[rd_v];
        coord_rd_reg <= coord_mem[rd_v][rd_d];
    end

    // Shared restoring divider step: one quotient bit per cycle.
    assign rem_sh = {rem_reg, quo_reg[SUM_W-1]};
    assign q_bit  = (rem_sh >= {1'b0, dvsr});

    // Quotient magnitude above 2^31 - 1 saturates; exactly 2^31 is fine when negative.
    assign q_hi = |quo_reg[SUM_W-1:DW-1];
    always_comb
    begin
        if (q_hi)
            mean = neg_reg ? svrc_pkg::Q_MIN : svrc_pkg::Q_MAX;
        else
            mean = neg_reg ? -$signed(quo_reg[DW-1:0]) : $signed(quo_reg[DW-1:0]);
    end

    assign out_free = !out_valid_reg || result.ready;
    assign dim_last = ((dcnt_reg + DC_W'(1)) == nd_use);

    always_comb
    begin
        st_next           = st_reg;
        cnt_next          = cnt_reg;
        dcnt_next         = dcnt_reg;
        rd_vld_next       = 1'b0;
        rd_idx_next       = VI_W'(cnt_reg);
        ans_next          = ans_reg;
        w_next            = w_reg;
        w2_next           = w2_reg;
        b_next            = b_reg;
        wc_next           = wc_reg;
        w2c_next          = w2c_reg;
        bc_next           = bc_reg;
        have2_next        = have2_reg;
        worst_next        = worst_reg;
        second_worst_next = second_worst_reg;
        best_next         = best_reg;
        sum_next          = sum_reg;
        neg_next          = neg_reg;
        quo_next          = quo_reg;
        rem_next          = rem_reg;
        dstep_next        = dstep_reg;
        best_cost_next    = best_cost_reg;
        dims_next         = dims_reg;
        vcnt_next         = vcnt_reg;
        out_valid_next    = out_valid_reg && !result.ready;
        out_kind_next     = out_kind_reg;
        out_worst_next    = out_worst_reg;
        out_second_next   = out_second_reg;
        out_best_next     = out_best_reg;
        out_dim_next      = out_dim_reg;
        out_coord_next    = out_coord_reg;
        out_cost_next     = out_cost_reg;
        out_last_next     = out_last_reg;

        if (cfg_wr && (cfg_idx == svrc_pkg::REG_DIMENSIONS))
            dims_next = pwdata[svrc_pkg::CFG_W-1:0];
        if (cfg_wr && (cfg_idx == svrc_pkg::REG_VERTEX_COUNT))
            vcnt_next = pwdata[svrc_pkg::CFG_W-1:0];

        case (st_reg)
            ST_IDLE:
            begin
                if (cmd_acc)
                begin
                    case (cmd.func)
                        svrc_pkg::FUNC_RANK:
                        begin
                            ans_next = 1'b0;
                            cnt_next = '0;
                            st_next  = ST_RANK_A;
                        end
                        svrc_pkg::FUNC_ANSWER:
                        begin
                            ans_next = 1'b1;
                            cnt_next = '0;
                            st_next  = ST_RANK_A;
                        end
                        svrc_pkg::FUNC_CENTROID:
                        begin
                            cnt_next  = '0;
                            dcnt_next = '0;
                            sum_next  = '0;
                            st_next   = ST_CEN_SUM;
                        end
                        default:
                        begin
                            st_next = ST_IDLE;
                        end
                    endcase
                end
            end

            // First pass: worst (strictly larger wins) and best (smaller or equal wins).
            ST_RANK_A:
            begin
                if (rd_vld_reg)
                begin
                    if (rd_idx_reg == '0)
                    begin
                        w_next  = '0;
                        b_next  = '0;
                        wc_next = cost_rd_reg;
                        bc_next = cost_rd_reg;
                    end
                    else
                    begin
                        if (cost_rd_reg > wc_reg)
                        begin
                            w_next  = rd_idx_reg;
                            wc_next = cost_rd_reg;
                        end
                        if (cost_rd_reg <= bc_reg)
                        begin
                            b_next  = rd_idx_reg;
                            bc_next = cost_rd_reg;
                        end
                    end
                end
                if (cnt_reg < nv_use)
                begin
                    rd_vld_next = 1'b1;
                    cnt_next    = cnt_reg + VC_W'(1);
                end
                else
                begin
                    cnt_next   = '0;
                    have2_next = 1'b0;
                    st_next    = ST_RANK_B;
                end
            end

            // Second pass: largest cost among all but the worst, lowest index on a tie.
            ST_RANK_B:
            begin
                if (rd_vld_reg && (rd_idx_reg != w_reg))
                begin
                    if (!have2_reg || (cost_rd_reg > w2c_reg))
                    begin
                        w2_next    = rd_idx_reg;
                        w2c_next   = cost_rd_reg;
                        have2_next = 1'b1;
                    end
                end
                if (cnt_reg < nv_use)
                begin
                    rd_vld_next = 1'b1;
                    cnt_next    = cnt_reg + VC_W'(1);
                end
                else
                begin
                    cnt_next = '0;
                    st_next  = ST_RANK_DONE;
                end
            end

            ST_RANK_DONE:
            begin
                worst_next        = w_reg;
                second_worst_next = w2_reg;
                best_next         = b_reg;
                dcnt_next         = '0;
                st_next           = ans_reg ? ST_ANS_COST : ST_RANK_PUT;
            end

            ST_RANK_PUT:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_kind_next   = svrc_pkg::KIND_RANK;
                    out_worst_next  = worst_reg;
                    out_second_next = second_worst_reg;
                    out_best_next   = best_reg;
                    out_dim_next    = '0;
                    out_coord_next  = '0;
                    out_cost_next   = '0;
                    out_last_next   = 1'b1;
                    st_next         = ST_IDLE;
                end
            end

            // A worst index outside the vertices in use excludes nothing.
            ST_CEN_SUM:
            begin
                if (rd_vld_reg && (rd_idx_reg != worst_reg))
                    sum_next = sum_reg + SUM_W'(coord_rd_reg);
                if (cnt_reg < nv_use)
                begin
                    rd_vld_next = 1'b1;
                    cnt_next    = cnt_reg + VC_W'(1);
                end
                else
                begin
                    cnt_next = '0;
                    st_next  = ST_DIV_LOAD;
                end
            end

            ST_DIV_LOAD:
            begin
                neg_next   = sum_reg[SUM_W-1];
                quo_next   = sum_reg[SUM_W-1] ? SUM_W'(-sum_reg) : SUM_W'(sum_reg);
                rem_next   = '0;
                dstep_next = DS_W'(SUM_W);
                st_next    = ST_DIV_RUN;
            end

            ST_DIV_RUN:
            begin
                if (q_bit)
                    rem_next = VC_W'(rem_sh - {1'b0, dvsr});
                else
                    rem_next = VC_W'(rem_sh);
                quo_next   = {quo_reg[SUM_W-2:0], q_bit};
                dstep_next = dstep_reg - DS_W'(1);
                if (dstep_reg == DS_W'(1))
                    st_next = ST_CEN_PUT;
            end

            ST_CEN_PUT:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_kind_next   = svrc_pkg::KIND_CENTROID;
                    out_worst_next  = worst_reg;
                    out_second_next = second_worst_reg;
                    out_best_next   = best_reg;
                    out_dim_next    = svrc_pkg::DIM_W'(dcnt_reg);
                    out_coord_next  = mean;
                    out_cost_next   = '0;
                    out_last_next   = dim_last;
                    if (dim_last)
                    begin
                        dcnt_next = '0;
                        st_next   = ST_IDLE;
                    end
                    else
                    begin
                        dcnt_next = dcnt_reg + DC_W'(1);
                        cnt_next  = '0;
                        sum_next  = '0;
                        st_next   = ST_CEN_SUM;
                    end
                end
            end

            ST_ANS_COST:
            begin
                st_next = ST_ANS_RD;
            end

            ST_ANS_RD:
            begin
                best_cost_next = cost_rd_reg;
                st_next        = ST_ANS_PUT;
            end

            ST_ANS_PUT:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_kind_next   = svrc_pkg::KIND_BEST;
                    out_worst_next  = worst_reg;
                    out_second_next = second_worst_reg;
                    out_best_next   = best_reg;
                    out_dim_next    = svrc_pkg::DIM_W'(dcnt_reg);
                    out_coord_next  = coord_rd_reg;
                    out_cost_next   = best_cost_reg;
                    out_last_next   = dim_last;
                    if (dim_last)
                    begin
                        dcnt_next = '0;
                        st_next   = ST_IDLE;
                    end
                    else
                    begin
                        dcnt_next = dcnt_reg + DC_W'(1);
                        st_next   = ST_ANS_RD;
                    end
                end
            end

            default:
            begin
                st_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg           <= ST_IDLE;
            cnt_reg          <= '0;
            dcnt_reg         <= '0;
            rd_vld_reg       <= 1'b0;
            rd_idx_reg       <= '0;
            ans_reg          <= 1'b0;
            w_reg            <= '0;
            w2_reg           <= '0;
            b_reg            <= '0;
            wc_reg           <= '0;
            w2c_reg          <= '0;
            bc_reg           <= '0;
            have2_reg        <= 1'b0;
            worst_reg        <= '0;
            second_worst_reg <= '0;
            best_reg         <= '0;
            sum_reg          <= '0;
            neg_reg          <= 1'b0;
            quo_reg          <= '0;
            rem_reg          <= '0;
            dstep_reg        <= '0;
            best_cost_reg    <= '0;
            dims_reg         <= svrc_pkg::DIMENSIONS_RST;
            vcnt_reg         <= svrc_pkg::VERTEX_COUNT_RST;
            out_valid_reg    <= 1'b0;
            out_kind_reg     <= '0;
            out_worst_reg    <= '0;
            out_second_reg   <= '0;
            out_best_reg     <= '0;
            out_dim_reg      <= '0;
            out_coord_reg    <= '0;
            out_cost_reg     <= '0;
            out_last_reg     <= 1'b0;
        end
        else
        begin
            st_reg           <= st_next;
            cnt_reg          <= cnt_next;
            dcnt_reg         <= dcnt_next;
            rd_vld_reg       <= rd_vld_next;
            rd_idx_reg       <= rd_idx_next;
            ans_reg          <= ans_next;
            w_reg            <= w_next;
            w2_reg           <= w2_next;
            b_reg            <= b_next;
            wc_reg           <= wc_next;
            w2c_reg          <= w2c_next;
            bc_reg           <= bc_next;
            have2_reg        <= have2_next;
            worst_reg        <= worst_next;
            second_worst_reg <= second_worst_next;
            best_reg         <= best_next;
            sum_reg          <= sum_next;
            neg_reg          <= neg_next;
            quo_reg          <= quo_next;
            rem_reg          <= rem_next;
            dstep_reg        <= dstep_next;
            best_cost_reg    <= best_cost_next;
            dims_reg         <= dims_next;
            vcnt_reg         <= vcnt_next;
            out_valid_reg    <= out_valid_next;
            out_kind_reg     <= out_kind_next;
            out_worst_reg    <= out_worst_next;
            out_second_reg   <= out_second_next;
            out_best_reg     <= out_best_next;
            out_dim_reg      <= out_dim_next;
            out_coord_reg    <= out_coord_next;
            out_cost_reg     <= out_cost_next;
            out_last_reg     <= out_last_next;
        end
    end

    assign result.valid              = out_valid_reg;
    assign result.kind               = out_kind_reg;
    assign result.worst_index        = svrc_pkg::VTX_W'(out_worst_reg);
    assign result.second_worst_index = svrc_pkg::VTX_W'(out_second_reg);
    assign result.best_index         = svrc_pkg::VTX_W'(out_best_reg);
    assign result.out_dim            = out_dim_reg;
    assign result.coord_value        = out_coord_reg;
    assign result.best_cost          = out_cost_reg;
    assign result.last               = out_last_reg;

    `SVRC_ASSERT_IMP(a_rank_is_last,
        result.valid && (result.kind == svrc_pkg::KIND_RANK), result.last,
        "ranking result without last")
    `SVRC_ASSERT_NXT(a_rank_starts,
        cmd.valid && cmd.ready && (cmd.func == svrc_pkg::FUNC_RANK), st_reg == ST_RANK_A,
        "rank request did not start the cost pass")
    `SVRC_ASSERT_IMP(a_rank_valid,
        st_reg == ST_RANK_PUT,
        (32'(worst_reg) < 32'(nv_use)) && (32'(best_reg) < 32'(nv_use))
            && (worst_reg != second_worst_reg),
        "latched ranks out of range or not distinct")

endmodule

/* tb/svrc_result_checker.sv */
`timescale 1ns / 100ps
// Result checker: watches the request, result and register ports, predicts and compares.
module svrc_result_checker
    import svrc_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    input  logic               pready,
    svrc_cmd_if                cmd,
    svrc_res_if                result,
    output int                 errors,
    output int                 pending,
    output int                 results_checked
);

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [VTX_W-1:0]  worst;
        logic [VTX_W-1:0]  second;
        logic [VTX_W-1:0]  best;
        logic [DIM_W-1:0]  dim;
        logic [DATA_W-1:0] coord;
        logic [DATA_W-1:0] cost;
        logic              last;
    } simplex_result_t;

    simplex_result_t expected_results[$];

    logic signed [DATA_W-1:0] coord_store [DEF_MAX_VERTICES][DEF_MAX_DIMS];
    logic signed [DATA_W-1:0] cost_store  [DEF_MAX_VERTICES];
    logic [VTX_W-1:0] worst_vtx;
    logic [VTX_W-1:0] second_vtx;
    logic [VTX_W-1:0] best_vtx;
    logic [CFG_W-1:0] cfg_dims;
    logic [CFG_W-1:0] cfg_verts;

    initial
    begin
        errors          = 0;
        pending         = 0;
        results_checked = 0;
    end

    function automatic int dims_in_use();
        if (cfg_dims < 1)
            return 1;
        if (cfg_dims > DEF_MAX_DIMS)
            return DEF_MAX_DIMS;
        return int'(cfg_dims);
    endfunction

    function automatic int verts_in_use();
        if (cfg_verts < 2)
            return 2;
        if (cfg_verts > DEF_MAX_VERTICES)
            return DEF_MAX_VERTICES;
        return int'(cfg_verts);
    endfunction

    task automatic report_mismatch(input string msg);
        errors++;
        $display("%0t mismatch: %s", $time, msg);
    endtask

    task automatic compare_field(input string name, input logic [DATA_W-1:0] got,
                                 input logic [DATA_W-1:0] want);
        if (got !== want)
            report_mismatch($sformatf("result %0d %s: got %0h, want %0h",
                                      results_checked, name, got, want));
    endtask

    function automatic void rank_by_cost();
        int n;
        int w;
        int w2;
        int b;
        bit have2;
        n     = verts_in_use();
        w     = 0;
        w2    = 0;
        b     = 0;
        have2 = 1'b0;
        for (int s = 1; s < n; s++)
            if (cost_store[s] > cost_store[w])
                w = s;
        // Second-worst is the largest of the rest, the lowest index winning a tie.
        for (int s = 0; s < n; s++)
            if (s != w && (!have2 || cost_store[s] > cost_store[w2]))
            begin
                w2    = s;
                have2 = 1'b1;
            end
        for (int s = 1; s < n; s++)
            if (cost_store[s] <= cost_store[b])
                b = s;
        worst_vtx  = VTX_W'(w);
        second_vtx = VTX_W'(w2);
        best_vtx   = VTX_W'(b);
    endfunction

    function automatic logic signed [DATA_W-1:0] centroid_mean(input int d);
        int nv;
        longint total;
        longint mean;
        nv    = verts_in_use();
        total = 0;
        // A stale worst index outside the vertices in use excludes nothing.
        for (int s = 0; s < nv; s++)
            if (s != int'(worst_vtx))
                total += coord_store[s][d];
        mean = total / longint'(nv - 1);
        if (mean > longint'(Q_MAX))
            mean = longint'(Q_MAX);
        if (mean < longint'(Q_MIN))
            mean = longint'(Q_MIN);
        return DATA_W'(mean);
    endfunction

    function automatic void push_result(input logic [KIND_W-1:0] kind,
                                        input logic [DIM_W-1:0] dim,
                                        input logic [DATA_W-1:0] coord,
                                        input logic [DATA_W-1:0] cost, input logic last);
        simplex_result_t r;
        r.kind   = kind;
        r.worst  = worst_vtx;
        r.second = second_vtx;
        r.best   = best_vtx;
        r.dim    = dim;
        r.coord  = coord;
        r.cost   = cost;
        r.last   = last;
        expected_results.push_back(r);
    endfunction

    function automatic void predict_request(input logic [FUNC_W-1:0] func,
                                            input logic [VTX_W-1:0] vtx,
                                            input logic [DIM_W-1:0] dim,
                                            input logic signed [DATA_W-1:0] val);
        int nd;
        nd = dims_in_use();
        case (func)
            FUNC_WR_COORD:
                if (vtx < DEF_MAX_VERTICES && dim < DEF_MAX_DIMS)
                    coord_store[vtx][dim] = val;
            FUNC_WR_COST:
                if (vtx < DEF_MAX_VERTICES)
                    cost_store[vtx] = val;
            FUNC_RANK:
            begin
                rank_by_cost();
                push_result(KIND_RANK, '0, '0, '0, 1'b1);
            end
            FUNC_CENTROID:
                for (int d = 0; d < nd; d++)
                    push_result(KIND_CENTROID, DIM_W'(d), centroid_mean(d), '0, d == nd - 1);
            FUNC_ANSWER:
            begin
                rank_by_cost();
                for (int d = 0; d < nd; d++)
                    push_result(KIND_BEST, DIM_W'(d), coord_store[best_vtx][d],
                                cost_store[best_vtx], d == nd - 1);
            end
            default:
                ;
        endcase
    endfunction

    task automatic check_result();
        simplex_result_t want;
        if (expected_results.size() == 0)
        begin
            report_mismatch($sformatf("result kind %0d dim %0d with no request pending",
                                      result.kind, result.out_dim));
        end
        else
        begin
            want = expected_results.pop_front();
            results_checked++;
            compare_field("kind", result.kind, want.kind);
            compare_field("worst_index", result.worst_index, want.worst);
            compare_field("second_worst_index", result.second_worst_index, want.second);
            compare_field("best_index", result.best_index, want.best);
            compare_field("out_dim", result.out_dim, want.dim);
            compare_field("coord_value", result.coord_value, want.coord);
            compare_field("best_cost", result.best_cost, want.cost);
            compare_field("last", result.last, want.last);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            worst_vtx  = '0;
            second_vtx = '0;
            best_vtx   = '0;
            cfg_dims   = DIMENSIONS_RST;
            cfg_verts  = VERTEX_COUNT_RST;
            expected_results.delete();
            pending = 0;
        end
        else
        begin
            if (result.valid && result.ready)
                check_result();
            if (psel && penable && pwrite && pready)
            begin
                if (paddr == {REG_DIMENSIONS, 2'b00})
                    cfg_dims = pwdata[CFG_W-1:0];
                else if (paddr == {REG_VERTEX_COUNT, 2'b00})
                    cfg_verts = pwdata[CFG_W-1:0];
            end
            if (cmd.valid && cmd.ready)
                predict_request(cmd.func, cmd.vertex, cmd.dim_index, cmd.value);
            pending = expected_results.size();
        end
    end

endmodule

/* tb/simplex_vertex_rank_centroid_tb.sv */
`timescale 1ns / 100ps
// Testbench top: clock, reset, register writes, request stimulus and the verdict.
module simplex_vertex_rank_centroid_tb;
    import svrc_pkg::*;

    localparam int CYCLE_LIMIT     = 1_000_000;
    localparam int SETTLE_CYCLES   = 64;
    localparam int HOLD_OFF_CYCLES = 600;

    logic               clk;
    logic               rst_n;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [PDATA_W-1:0] pwdata;
    logic [PDATA_W-1:0] prdata;
    logic               pready;

    svrc_cmd_if cmd_ch ();
    svrc_res_if res_ch ();

    int errors;
    int pending;
    int results_checked;
    int send_idle_pct;
    int recv_idle_pct;
    int requests_sent = 0;
    int reads_sent    = 0;
    int cycle_count   = 0;
    int dims_used;
    int verts_used;
    bit holding = 1'b0;
    bit coord_written [DEF_MAX_VERTICES][DEF_MAX_DIMS];
    bit cost_written  [DEF_MAX_VERTICES];
    event hold_off_ev;

    simplex_vertex_rank_centroid u_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cmd     (cmd_ch),
        .result  (res_ch)
    );

    svrc_result_checker u_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .pready          (pready),
        .cmd             (cmd_ch),
        .result          (res_ch),
        .errors          (errors),
        .pending         (pending),
        .results_checked (results_checked)
    );

    initial
        clk = 1'b0;

    always #5 clk = ~clk;

    always @(negedge clk)
        res_ch.ready <= !holding && ($urandom_range(99) >= recv_idle_pct);

    // Long output stall: the block has to fill up and push back on requests.
    always
    begin
        @(hold_off_ev);
        @(posedge clk);
        holding = 1'b1;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
        holding = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("simplex_vertex_rank_centroid regression: fail");
            $finish;
        end
    end

    function automatic logic signed [DATA_W-1:0] pick_word();
        case ($urandom_range(7))
            0: return Q_MAX;
            1: return Q_MIN;
            2: return '0;
            3: return '1;
            4: return DATA_W'($urandom_range(262143)) - 32'd131072;
            default: return $urandom;
        endcase
    endfunction

    // Costs come mostly from a few whole values so that ties are common.
    function automatic logic signed [DATA_W-1:0] pick_cost();
        int k;
        k = $urandom_range(4);
        if ($urandom_range(3) == 0)
            return pick_word();
        return DATA_W'((k - 2) * 65536);
    endfunction

    task automatic reg_write(input logic reg_index, input logic [CFG_W-1:0] val);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {reg_index, 2'b00};
        pwdata  <= PDATA_W'(val);
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic send_request(input logic [FUNC_W-1:0] func, input logic [VTX_W-1:0] vtx,
                                input logic [DIM_W-1:0] dim,
                                input logic signed [DATA_W-1:0] val);
        while ($urandom_range(99) < send_idle_pct)
        begin
            @(negedge clk);
            cmd_ch.valid <= 1'b0;
        end
        @(negedge clk);
        cmd_ch.valid     <= 1'b1;
        cmd_ch.func      <= func;
        cmd_ch.vertex    <= vtx;
        cmd_ch.dim_index <= dim;
        cmd_ch.value     <= val;
        do @(posedge clk); while (!cmd_ch.ready);
        requests_sent++;
        if (func == FUNC_WR_COORD && vtx < DEF_MAX_VERTICES)
            coord_written[vtx][dim] = 1'b1;
        if (func == FUNC_WR_COST && vtx < DEF_MAX_VERTICES)
            cost_written[vtx] = 1'b1;
    endtask

    task automatic wait_drained();
        @(negedge clk);
        cmd_ch.valid <= 1'b0;
        wait (pending == 0);
    endtask

    // Every entry a read may touch under the current setting gets a value first.
    task automatic send_read(input logic [FUNC_W-1:0] func);
        for (int v = 0; v < verts_used; v++)
        begin
            if (!cost_written[v])
                send_request(FUNC_WR_COST, VTX_W'(v), '0, pick_cost());
            for (int d = 0; d < dims_used; d++)
                if (!coord_written[v][d])
                    send_request(FUNC_WR_COORD, VTX_W'(v), DIM_W'(d), pick_word());
        end
        send_request(func, VTX_W'($urandom_range(15)), DIM_W'($urandom_range(7)), $urandom);
        reads_sent++;
    endtask

    task automatic configure(input logic [CFG_W-1:0] dims, input logic [CFG_W-1:0] verts,
                             input int sender_pct, input int receiver_pct);
        wait_drained();
        // Writes leave no result behind, so give the sequencer time to go idle.
        repeat (SETTLE_CYCLES) @(posedge clk);
        send_idle_pct = sender_pct;
        recv_idle_pct = receiver_pct;
        reg_write(REG_DIMENSIONS, dims);
        reg_write(REG_VERTEX_COUNT, verts);
        dims_used  = (dims < 1) ? 1 : (dims > DEF_MAX_DIMS) ? DEF_MAX_DIMS : int'(dims);
        verts_used = (verts < 2) ? 2 : (verts > DEF_MAX_VERTICES) ? DEF_MAX_VERTICES
                                                                   : int'(verts);
    endtask

    task automatic send_random_request();
        int pick;
        logic [VTX_W-1:0] vtx;
        if ($urandom_range(39) == 0)
            wait_drained();
        pick = $urandom_range(99);
        if ($urandom_range(9) == 0)
            vtx = VTX_W'($urandom_range(DEF_MAX_VERTICES - 1));
        else
            vtx = VTX_W'($urandom_range(verts_used - 1));
        if (pick < 40)
            send_request(FUNC_WR_COORD, vtx, DIM_W'($urandom_range(7)), pick_word());
        else if (pick < 60)
            send_request(FUNC_WR_COST, vtx, DIM_W'($urandom_range(7)), pick_cost());
        else if (pick < 70)
            send_read(FUNC_RANK);
        else if (pick < 80)
            send_read(FUNC_CENTROID);
        else if (pick < 90)
            send_read(FUNC_ANSWER);
        else if (pick < 95)
            send_request($urandom_range(1) ? FUNC_WR_COST : FUNC_WR_COORD,
                         VTX_W'($urandom_range(15, DEF_MAX_VERTICES)),
                         DIM_W'($urandom_range(7)), $urandom);
        else
            send_request(FUNC_W'($urandom_range(7, 5)), VTX_W'($urandom_range(15)),
                         DIM_W'($urandom_range(7)), $urandom);
    endtask

    task automatic run_phase(input logic [CFG_W-1:0] dims, input logic [CFG_W-1:0] verts,
                             input int sender_pct, input int receiver_pct, input int count);
        configure(dims, verts, sender_pct, receiver_pct);
        repeat (count) send_random_request();
    endtask

    initial
    begin
        psel             = 1'b0;
        penable          = 1'b0;
        pwrite           = 1'b0;
        paddr            = '0;
        pwdata           = '0;
        cmd_ch.valid     = 1'b0;
        cmd_ch.func      = FUNC_WR_COORD;
        cmd_ch.vertex    = '0;
        cmd_ch.dim_index = '0;
        cmd_ch.value     = '0;
        res_ch.ready     = 1'b0;
        rst_n            = 1'b0;
        send_idle_pct    = 15;
        recv_idle_pct    = 76;
        dims_used        = DIMENSIONS_RST;
        verts_used       = VERTEX_COUNT_RST;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Reset setting, two coordinates and three vertices: extremes and a worst tie.
        send_request(FUNC_WR_COORD, 4'd0, 3'd0, Q_MAX);
        send_request(FUNC_WR_COORD, 4'd0, 3'd1, Q_MIN);
        send_request(FUNC_WR_COORD, 4'd1, 3'd0, Q_MAX);
        send_request(FUNC_WR_COORD, 4'd1, 3'd1, Q_MIN);
        send_request(FUNC_WR_COORD, 4'd2, 3'd0, -32'sd1);
        send_request(FUNC_WR_COORD, 4'd2, 3'd1, 32'sd1);
        send_request(FUNC_WR_COST, 4'd0, 3'd0, 32'sh0005_0000);
        send_request(FUNC_WR_COST, 4'd1, 3'd0, 32'sh0005_0000);
        send_request(FUNC_WR_COST, 4'd2, 3'd0, Q_MIN);
        send_read(FUNC_RANK);
        send_read(FUNC_CENTROID);
        send_read(FUNC_ANSWER);
        // Unknown functions and out-of-store writes leave no trace; vertex 8 is kept.
        send_request(3'd5, 4'd0, 3'd0, Q_MAX);
        send_request(3'd6, 4'd1, 3'd1, Q_MAX);
        send_request(3'd7, 4'd15, 3'd7, Q_MIN);
        send_request(FUNC_WR_COST, 4'd9, 3'd0, Q_MIN);
        send_request(FUNC_WR_COORD, 4'd15, 3'd7, Q_MAX);
        send_request(FUNC_WR_COORD, 4'd8, 3'd7, 32'sh1234_5678);
        // Make vertex 2 worst, then drop it from use: the centroid sums both
        // remaining vertices over one and saturates at both ends.
        send_request(FUNC_WR_COST, 4'd2, 3'd0, Q_MAX);
        send_read(FUNC_RANK);
        configure(4'd2, 4'd2, 15, 76);
        send_read(FUNC_CENTROID);
        send_read(FUNC_ANSWER);

        configure(4'd8, 4'd9, 15, 76);
        ->hold_off_ev;
        repeat (8) send_read(FUNC_RANK);
        repeat (10) send_random_request();
        run_phase(4'd3, 4'd4, 15, 76, 10);
        run_phase(4'd1, 4'd2, 76, 15, 10);
        run_phase(4'd0, 4'd15, 76, 15, 10);
        run_phase(4'd15, 4'd0, 76, 15, 10);
        run_phase(4'd5, 4'd6, 0, 0, 10);
        run_phase(4'd2, 4'd3, 0, 0, 10);

        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
        $display("checked %0d results from %0d requests (%0d rank, centroid or answer)",
                 results_checked, requests_sent, reads_sent);
        $display("over nine register settings incl. out-of-range, stale worst and a %0d-cycle stall",
                 HOLD_OFF_CYCLES);
        if (errors == 0)
            $display("simplex_vertex_rank_centroid regression: pass");
        else
            $display("simplex_vertex_rank_centroid regression: fail");
        $finish;
    end

endmodule
